>>> src/ida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ida_pkg: shared types and constants of the identifier allocator
// Request and result codes, field widths, reset values and the control and
// status groups that pass between the allocator and its recycle pool.
// ----------------------------------------------------------------------------
package ida_pkg;

  // field widths
  localparam int unsigned ID_W  = 16;
  localparam int unsigned THR_W = 11;

  // defaults
  localparam int unsigned POOL_DEPTH_DEF = 1024;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(1000);

  // identifier limits
  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
  localparam logic [ID_W-1:0] ID_LAST  = {ID_W{1'b1}};

  // request codes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // result codes
  typedef enum logic [1:0] {
    ST_NEW       = 2'd0,
    ST_REUSED    = 2'd1,
    ST_FREE_OK   = 2'd2,
    ST_FREE_DROP = 2'd3
  } status_e;

  // pool requests, at most one set per cycle
  typedef struct packed {
    logic push;
    logic pop;
  } pool_req_t;

  // pool occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
    logic reuse;
  } pool_stat_t;

endpackage

>>> src/ida_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ida_pool: recycle FIFO of freed identifiers
// Circular buffer in a single memory with head, tail and fill count. The pop
// data is read into a register at the edge that takes the pop.
// ----------------------------------------------------------------------------
module ida_pool #(
  parameter int unsigned DEPTH = ida_pkg::POOL_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ida_pkg::pool_req_t          req_i,
  input  logic [ida_pkg::ID_W-1:0]    push_data_i,
  input  logic [ida_pkg::THR_W-1:0]   threshold_i,
  output ida_pkg::pool_stat_t         stat_o,
  output logic [ida_pkg::ID_W-1:0]    pop_data_o
);
  import ida_pkg::*;

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CW > THR_W) ? CW : THR_W;

  logic [ID_W-1:0] mem_q [DEPTH];
  logic [ID_W-1:0] rd_q;
  logic [AW-1:0]   head_q, head_d;
  logic [AW-1:0]   tail_q, tail_d;
  logic [CW-1:0]   count_q, count_d;

  // occupancy flags
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.reuse = (CMP_W'(count_q) >= CMP_W'(threshold_i));

  // pointer and count update
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.push) begin
      tail_d  = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (req_i.pop) begin
      head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // storage, write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[tail_q] <= push_data_i;
    end
    if (req_i.pop) begin
      rd_q <= mem_q[head_q];
    end
  end

  assign pop_data_o = rd_q;

endmodule

>>> src/id_allocator_with_recycle_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_allocator_with_recycle_fifo: identifier allocator with recycle pool
// Issues 16-bit identifiers from a wrapping counter or from a FIFO of freed
// identifiers, and queues freed identifiers into that FIFO.
// ----------------------------------------------------------------------------
// One request is taken in every cycle in which the result register is empty
// or its result is taken in the same cycle; each result shows in the cycle
// after its request. An allocate issues from the counter (1 to 65535,
// wrapping past 0) while the pool holds fewer entries than reuse_threshold
// or is empty, and otherwise the oldest freed identifier. A free into a full
// pool is dropped and flagged. Pool entries are only read after they were
// written, so the pool memory needs no clearing after reset. The user must
// write the threshold only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module id_allocator_with_recycle_fifo #(
  parameter int unsigned POOL_DEPTH = ida_pkg::POOL_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ida_pkg::THR_W-1:0]  cfg_data_i,
  // requests
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [ida_pkg::ID_W-1:0]   freed_id_i,
  // results
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ida_pkg::ID_W-1:0]   issued_id_o,
  output logic [1:0]                 status_o
);
  import ida_pkg::*;

  logic [THR_W-1:0] threshold_q;
  logic [ID_W-1:0]  counter_q, counter_d;
  logic             out_valid_q;
  logic [ID_W-1:0]  id_q, id_d;
  status_e          status_q, status_d;
  logic             in_fire;
  pool_req_t        pool_req;
  pool_stat_t       pool_stat;
  logic [ID_W-1:0]  pool_data;

  // threshold register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      threshold_q <= cfg_data_i;
    end
  end

  // a beat enters when the result register is free or drains now
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // request decode
  always_comb begin
    pool_req  = '0;
    counter_d = counter_q;
    id_d      = '0;
    status_d  = ST_NEW;
    if (operation_i == OP_FREE) begin
      if (pool_stat.full) begin
        status_d = ST_FREE_DROP;
      end else begin
        pool_req.push = in_fire;
        status_d      = ST_FREE_OK;
      end
    end else if (pool_stat.reuse && !pool_stat.empty) begin
      pool_req.pop = in_fire;
      status_d     = ST_REUSED;
    end else begin
      id_d      = counter_q;
      counter_d = (counter_q == ID_LAST) ? ID_FIRST : counter_q + 1'b1;
      status_d  = ST_NEW;
    end
  end

  // counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= ID_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        counter_q <= counter_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q     <= id_d;
      status_q <= status_d;
    end
  end

  ida_pool #(
    .DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (pool_req),
    .push_data_i (freed_id_i),
    .threshold_i (threshold_q),
    .stat_o      (pool_stat),
    .pop_data_o  (pool_data)
  );

  // reused identifiers come from the pool read register
  assign out_valid_o = out_valid_q;
  assign issued_id_o = (status_q == ST_REUSED) ? pool_data : id_q;
  assign status_o    = status_q;

endmodule

>>> src/ida_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ida_checker: port checks of the identifier allocator
// Watches the top-level ports for result ordering and identifier rules and
// is bound to the top level.
// ----------------------------------------------------------------------------
module ida_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_o,
  input  logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  logic [ida_pkg::ID_W-1:0]  issued_id_o,
  input  logic [1:0]                status_o
);
  import ida_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(issued_id_o) && $stable(status_o))
    else $error("stalled result beat changed");

  // every accepted request shows a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request produced no result");

  // requests are held back only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without a waiting result");

  // frees return identifier zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FREE_OK || status_o == ST_FREE_DROP) |->
      issued_id_o == '0)
    else $error("free result carries an identifier");

  // the counter never issues the reserved zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NEW |-> issued_id_o != '0)
    else $error("counter issued identifier zero");

endmodule

bind id_allocator_with_recycle_fifo ida_checker u_ida_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .issued_id_o (issued_id_o),
  .status_o    (status_o)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the identifier allocator
// Drives allocate and free requests through the valid/stall request port and
// checks every result beat against a cycle-free predictor of the counter and
// recycle pool. The bench steps through several reuse thresholds, reuses and
// empties the pool, and holds the result side off long enough to stall input.
// ----------------------------------------------------------------------------
module testbench;
  import ida_pkg::*;

  localparam int unsigned POOL_DEPTH = POOL_DEPTH_DEF;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_LINES = 30;

  // --------------------------------------------------------------------------
  // predictor of issued identifiers and queue of expected result beats
  // --------------------------------------------------------------------------
  class alloc_tracker;
    typedef struct {
      logic [ID_W-1:0] id;
      status_e         st;
    } issue_t;

    logic [THR_W-1:0] threshold;
    logic [ID_W-1:0]  counter;
    logic [ID_W-1:0]  free_ids[$];
    issue_t           pending_issues[$];
    int               errors;
    int               checked;
    int               per_status[4];
    int               wraps;

    function new();
      threshold = THRESHOLD_RESET;
      counter   = ID_FIRST;
      errors    = 0;
      checked   = 0;
      wraps     = 0;
      foreach (per_status[i]) per_status[i] = 0;
    endfunction

    function void set_threshold(logic [THR_W-1:0] value);
      threshold = value;
    endfunction

    // work out the result of one accepted request
    function void take_request(op_e op, logic [ID_W-1:0] fid);
      issue_t res;
      int used;
      used = free_ids.size();
      res.id = '0;
      if (op == OP_ALLOC) begin
        if (used < int'(threshold) || used == 0) begin
          res.id = counter;
          res.st = ST_NEW;
          if (counter == ID_LAST) begin
            counter = ID_FIRST;
            wraps++;
          end else begin
            counter = counter + 1'b1;
          end
        end else begin
          res.id = free_ids.pop_front();
          res.st = ST_REUSED;
        end
      end else begin
        if (used >= int'(POOL_DEPTH)) begin
          res.st = ST_FREE_DROP;
        end else begin
          free_ids.push_back(fid);
          res.st = ST_FREE_OK;
        end
      end
      pending_issues.push_back(res);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_LINES) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // compare one result beat with the oldest expectation
    task check_issue(logic [ID_W-1:0] id, logic [1:0] st);
      issue_t exp;
      if (pending_issues.size() == 0) begin
        report_mismatch($sformatf("unexpected result id %h status %0d", id, st));
        return;
      end
      exp = pending_issues.pop_front();
      checked++;
      per_status[exp.st]++;
      if (id !== exp.id)
        report_mismatch($sformatf("issued_id %h, expected %h (%s)", id, exp.id,
                                  exp.st.name()));
      if (st !== exp.st)
        report_mismatch($sformatf("status %0d, expected %s", st, exp.st.name()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals
  // --------------------------------------------------------------------------
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [THR_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             operation_i = 1'b0;
  logic [ID_W-1:0]  freed_id_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ID_W-1:0]  issued_id_o;
  logic [1:0]       status_o;

  alloc_tracker sb = new();

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     hold_go = 1'b0;
  int     hold_left = 0;
  longint cycles = 0;
  int     sent = 0;

  id_allocator_with_recycle_fifo #(
    .POOL_DEPTH (POOL_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .freed_id_i  (freed_id_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .issued_id_o (issued_id_o),
    .status_o    (status_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cycle count
  always @(posedge clk_i) cycles <= cycles + 1;

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             sb.pending_issues.size());
    $display("Simulation FAILED");
    $finish;
  end

  // result side: check accepted beats, drive stall with optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_issue(issued_id_o, status_o);
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // offer one request beat and hold it until it is taken
  task automatic send_req(input op_e op, input logic [ID_W-1:0] fid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    freed_id_i  <= fid;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_request(op, fid);
    sent++;
  endtask

  task automatic send_free(input logic [ID_W-1:0] fid);
    send_req(OP_FREE, fid);
  endtask

  task automatic send_alloc();
    send_req(OP_ALLOC, ID_W'($urandom));
  endtask

  // stop offering and wait until every expected beat has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_issues.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_threshold(value);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= THR_W'($urandom);
    @(posedge clk_i);
  endtask

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(5))
      0:       return '0;
      1:       return THR_W'(1);
      2:       return THR_W'($urandom_range(2, 16));
      3:       return THRESHOLD_RESET;
      4:       return THR_W'(POOL_DEPTH);
      default: return THR_W'($urandom_range(0, POOL_DEPTH));
    endcase
  endfunction

  // random bursts: recycle pairs, free and alloc runs, and scattered noise
  task automatic run_random(input int count);
    int stop_at;
    int len;
    int next_cfg;
    stop_at  = sent + count;
    next_cfg = sent + 40 + $urandom_range(40);
    while (sent < stop_at) begin
      len = $urandom_range(1, 12);
      case ($urandom_range(3))
        0: repeat (len) send_free(ID_W'($urandom));
        1: repeat (len) send_alloc();
        2: repeat (len) send_req(op_e'($urandom_range(1)), ID_W'($urandom));
        default: begin
          repeat (len) send_free(ID_W'($urandom));
          repeat (len) send_alloc();
        end
      endcase
      if (sent >= next_cfg) begin
        write_threshold(pick_threshold());
        next_cfg = sent + 40 + $urandom_range(40);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset threshold, free of zero and all-ones, pattern ids
    send_alloc();
    send_free('0);
    send_free(ID_LAST);
    send_free(16'h5555);
    send_free(16'hAAAA);
    send_alloc();
    // threshold zero: pop until empty, then empty pool falls back to counter
    write_threshold('0);
    repeat (5) send_alloc();
    // small threshold: reuse at the boundary, counter below it
    write_threshold(THR_W'(2));
    send_free(16'h0007);
    send_free(16'h0008);
    send_alloc();
    send_alloc();
    // threshold above pool depth: always from the counter
    write_threshold({THR_W{1'b1}});
    send_free(16'h1234);
    send_alloc();
    send_free(ID_W'($urandom));
    send_alloc();

    // random part in three idling modes
    write_threshold(pick_threshold());
    send_idle_pct = 11;
    recv_idle_pct = 81;
    run_random(160);
    drain();
    send_idle_pct = 81;
    recv_idle_pct = 11;
    run_random(160);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(80);
    // long receiver hold-off while requests keep coming
    hold_go = 1'b1;
    run_random(80);

    drain();
    repeat (10) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked, %0d errors", sent, sb.checked,
             sb.errors);
    $display("new %0d, reused %0d, free ok %0d, free dropped %0d, counter wraps %0d",
             sb.per_status[ST_NEW], sb.per_status[ST_REUSED], sb.per_status[ST_FREE_OK],
             sb.per_status[ST_FREE_DROP], sb.wraps);
    if (sb.errors == 0 && sb.pending_issues.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> id_allocator_with_recycle_fifo.f
src/ida_pkg.sv
src/ida_pool.sv
src/id_allocator_with_recycle_fifo.sv
src/ida_checker.sv
tb/testbench.sv
